[rtl/core/rpd_pkg.sv]
`default_nettype none
package rpd_pkg;

  localparam int unsigned CH_MAX       = 5;
  localparam int unsigned CHANNELS_DEF = 5;
  localparam int unsigned APB_DW       = 64;
  localparam int unsigned APB_AW       = 6;

  localparam logic [63:0] NEUTRAL_LOW_RST  = 64'h0BB8_0BB8_0BB8_0BB8;
  localparam logic [63:0] FAILSAFE_LOW_RST = 64'h0BB8_0BB8_0BB8_07D0;
  localparam logic [31:0] LAST_WORDS_RST   = 32'h0BB8_0BB8;
  localparam logic [4:0]  REVERSE_RST      = 5'd0;
  localparam logic [15:0] VALID_MIN_RST    = 16'd1600;
  localparam logic [15:0] VALID_MAX_RST    = 16'd4400;
  localparam logic [2:0]  LPF_SHIFT_RST    = 3'd2;

  typedef enum logic [2:0] {
    REG_NEUTRAL_LOW  = 3'd0,
    REG_FAILSAFE_LOW = 3'd1,
    REG_LAST_WORDS   = 3'd2,
    REG_REVERSE_MASK = 3'd3,
    REG_VALID_MIN    = 3'd4,
    REG_VALID_MAX    = 3'd5,
    REG_LPF_SHIFT    = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef struct packed {
    logic [15:0] valid_min;
    logic [15:0] valid_max;
    logic [2:0]  lpf_shift;
  } lane_cfg_t;

  // what a lane saw on this beat, for the frame counter chain
  typedef struct packed {
    logic rise;
    logic fall_ok;
  } lane_evt_t;

endpackage
`default_nettype wire

[rtl/core/rpd_lane.sv]
`default_nettype none
module rpd_lane
  import rpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        edge_fire_i,
  input  wire logic        check_fire_i,
  input  wire logic        level_i,
  input  wire logic [31:0] timestamp_i,
  input  wire lane_cfg_t   cfg_i,
  input  wire logic [15:0] failsafe_i,
  output lane_evt_t        evt_o,
  output logic [15:0]      width_d_o,
  output logic             mark_o
);

  logic [31:0] rise_q, rise_d;
  logic [15:0] width_q, width_d;
  logic        mark_q, mark_d;

  logic [31:0] pulse;
  logic        in_window;
  logic [15:0] diff, step, smooth;

  always_comb begin
    pulse     = timestamp_i - rise_q;
    in_window = (pulse >= {16'd0, cfg_i.valid_min}) && (pulse <= {16'd0, cfg_i.valid_max});
    diff      = width_q - pulse[15:0];
    step      = $signed(diff) >>> cfg_i.lpf_shift;
    // an empty filter takes the sample as is
    smooth    = (width_q == 16'd0) ? pulse[15:0] : width_q - step;

    evt_o.rise    = edge_fire_i & level_i;
    evt_o.fall_ok = edge_fire_i & ~level_i & in_window;

    rise_d  = rise_q;
    width_d = width_q;
    mark_d  = mark_q;
    if (evt_o.rise) begin
      rise_d = timestamp_i;
    end
    if (evt_o.fall_ok) begin
      width_d = smooth;
      mark_d  = 1'b1;
    end
    if (check_fire_i) begin
      if (!mark_q && (failsafe_i != 16'd0)) begin
        width_d = failsafe_i;
      end
      mark_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= '0;
      width_q <= '0;
      mark_q  <= 1'b0;
    end else begin
      rise_q  <= rise_d;
      width_q <= width_d;
      mark_q  <= mark_d;
    end
  end

  assign width_d_o = width_d;
  assign mark_o    = mark_q;

endmodule
`default_nettype wire

[rtl/core/rpd_frame.sv]
`default_nettype none
module rpd_frame
  import rpd_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lane_evt_t           evt_i [CHANNELS],
  input  wire logic                check_fire_i,
  input  wire logic [CHANNELS-1:0] marks_i,
  output logic [7:0]               frame_d_o,
  output logic                     lost_o
);

  logic [7:0] frame_q, frame_d;
  logic [7:0] seq_q [CHANNELS];
  logic [7:0] seq_d [CHANNELS];

  // channels resolve in ascending order; each sees the counter the previous left
  always_comb begin
    frame_d = frame_q;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      seq_d[ch] = seq_q[ch];
      if (evt_i[ch].rise) begin
        if (8'(frame_d + 8'd1) == seq_q[ch]) begin
          frame_d = 8'(frame_d + 8'd1);
        end else begin
          seq_d[ch] = frame_d;
        end
      end else if (evt_i[ch].fall_ok) begin
        seq_d[ch] = 8'(seq_q[ch] + 8'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        seq_q[ch] <= '0;
      end
    end else begin
      frame_q <= frame_d;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        seq_q[ch] <= seq_d[ch];
      end
    end
  end

  assign frame_d_o = frame_d;
  assign lost_o    = check_fire_i && (marks_i != {CHANNELS{1'b1}});

endmodule
`default_nettype wire

[rtl/core/rc_pwm_multichannel_decoder_unit.sv]
// Five-channel RC servo pulse-width decoder. Each input beat is either a pin edge event
// (timestamp, pin levels, changed pins) or a periodic failsafe check, and yields exactly
// one result beat carrying all channel widths, the frame count and the loss flag. One
// beat is taken every clock unless stalled: the per-channel lanes and frame counter chain
// are combinational, the result is registered for the cycle after its beat, and
// input stall follows output stall only while that register holds an untaken result.
// Configuration sits on a 64-bit APB port, register i at byte address 8*i, and may be
// written only while no result is pending. There is no clearing pass after reset.
`default_nettype none
module rc_pwm_multichannel_decoder_unit
  import rpd_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              operation_i,
  input  wire logic [31:0]       timestamp_i,
  input  wire logic [4:0]        pin_levels_i,
  input  wire logic [4:0]        pin_changed_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [15:0]            channel0_value_o,
  output logic [15:0]            channel1_value_o,
  output logic [15:0]            channel2_value_o,
  output logic [15:0]            channel3_value_o,
  output logic [15:0]            channel4_value_o,
  output logic [7:0]             frame_count_o,
  output logic                   signal_lost_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // ---------------- configuration registers
  logic [63:0] neutral_low_q, failsafe_low_q;
  logic [31:0] last_words_q;
  logic [4:0]  reverse_q;
  logic [15:0] valid_min_q, valid_max_q;
  logic [2:0]  lpf_shift_q;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_low_q  <= NEUTRAL_LOW_RST;
      failsafe_low_q <= FAILSAFE_LOW_RST;
      last_words_q   <= LAST_WORDS_RST;
      reverse_q      <= REVERSE_RST;
      valid_min_q    <= VALID_MIN_RST;
      valid_max_q    <= VALID_MAX_RST;
      lpf_shift_q    <= LPF_SHIFT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NEUTRAL_LOW:  neutral_low_q  <= pwdata;
        REG_FAILSAFE_LOW: failsafe_low_q <= pwdata;
        REG_LAST_WORDS:   last_words_q   <= pwdata[31:0];
        REG_REVERSE_MASK: reverse_q      <= pwdata[4:0];
        REG_VALID_MIN:    valid_min_q    <= pwdata[15:0];
        REG_VALID_MAX:    valid_max_q    <= pwdata[15:0];
        REG_LPF_SHIFT:    lpf_shift_q    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NEUTRAL_LOW:  prdata = neutral_low_q;
      REG_FAILSAFE_LOW: prdata = failsafe_low_q;
      REG_LAST_WORDS:   prdata = {32'd0, last_words_q};
      REG_REVERSE_MASK: prdata = {59'd0, reverse_q};
      REG_VALID_MIN:    prdata = {48'd0, valid_min_q};
      REG_VALID_MAX:    prdata = {48'd0, valid_max_q};
      REG_LPF_SHIFT:    prdata = {61'd0, lpf_shift_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------- handshake
  logic out_valid_q;
  logic accept;
  logic edge_beat, check_beat;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign edge_beat  = accept && (op_e'(operation_i) == OP_EDGE);
  assign check_beat = accept && (op_e'(operation_i) == OP_CHECK);

  // ---------------- lanes
  lane_cfg_t           lane_cfg;
  lane_evt_t           lane_evt [CHANNELS];
  logic [15:0]         lane_width_d [CHANNELS];
  logic [CHANNELS-1:0] marks;
  logic [7:0]          frame_d;
  logic                lost;

  assign lane_cfg.valid_min = valid_min_q;
  assign lane_cfg.valid_max = valid_max_q;
  assign lane_cfg.lpf_shift = lpf_shift_q;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic [15:0] failsafe;
    if (ch < 4) begin : g_low
      assign failsafe = failsafe_low_q[16*ch +: 16];
    end else begin : g_last
      assign failsafe = last_words_q[31:16];
    end

    rpd_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .edge_fire_i  (edge_beat && pin_changed_i[ch]),
      .check_fire_i (check_beat),
      .level_i      (pin_levels_i[ch]),
      .timestamp_i  (timestamp_i),
      .cfg_i        (lane_cfg),
      .failsafe_i   (failsafe),
      .evt_o        (lane_evt[ch]),
      .width_d_o    (lane_width_d[ch]),
      .mark_o       (marks[ch])
    );
  end

  rpd_frame #(
    .CHANNELS (CHANNELS)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (lane_evt),
    .check_fire_i (check_beat),
    .marks_i      (marks),
    .frame_d_o    (frame_d),
    .lost_o       (lost)
  );

  // ---------------- result register
  logic [15:0] out_width_q [CHANNELS];
  logic [7:0]  out_frame_q;
  logic        out_lost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_frame_q <= '0;
      out_lost_q  <= 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        out_width_q[ch] <= '0;
      end
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_frame_q <= frame_d;
        out_lost_q  <= lost;
        for (int ch = 0; ch < CHANNELS; ch++) begin
          out_width_q[ch] <= lane_width_d[ch];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // mirror about neutral; user keeps config stable while result pending; not enforced
  logic [15:0] ch_value [CH_MAX];

  for (genvar ch = 0; ch < CH_MAX; ch++) begin : g_out
    if (ch < CHANNELS) begin : g_used
      logic [15:0] neutral;
      if (ch < 4) begin : g_low
        assign neutral = neutral_low_q[16*ch +: 16];
      end else begin : g_last
        assign neutral = last_words_q[15:0];
      end
      assign ch_value[ch] = (reverse_q[ch] && (out_width_q[ch] != 16'd0))
                          ? 16'({neutral, 1'b0} - {1'b0, out_width_q[ch]})
                          : out_width_q[ch];
    end else begin : g_unused
      assign ch_value[ch] = 16'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel0_value_o = ch_value[0];
  assign channel1_value_o = ch_value[1];
  assign channel2_value_o = ch_value[2];
  assign channel3_value_o = ch_value[3];
  assign channel4_value_o = ch_value[4];
  assign frame_count_o    = out_frame_q;
  assign signal_lost_o    = out_lost_q;

  // ---------------- assertions
  a_edge_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_beat |=> !signal_lost_o)
    else $error("loss flagged on an edge beat");

  a_check_clears_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    check_beat |=> (marks == '0))
    else $error("update marks survived a check beat");

  a_check_flags_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    check_beat && (marks != {CHANNELS{1'b1}}) |=> signal_lost_o)
    else $error("missed update not flagged");

  a_check_keeps_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    check_beat |=> (frame_count_o == $past(out_frame_q)))
    else $error("frame count moved on a check beat");

endmodule
`default_nettype wire
